### sv/skp_pkg.sv
`default_nettype none

package skp_pkg;

    // Default sizing of the node store and of the stored coordinates.
    localparam int DEF_MAX_NODES  = 64;
    localparam int DEF_COORD_BITS = 16;

    // Fixed field widths of the channels and of the configuration port.
    localparam int OP_W     = 2;
    localparam int DIM_W    = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_HEIGHT = 1'b1;

    // Reset value of both bin dimensions.
    localparam logic [DIM_W-1:0] BIN_RESET = 16'd1024;

    // Operation codes. The spare code behaves as a find.
    localparam logic [OP_W-1:0] OP_FIND  = 2'd0;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

### sv/skp_if.sv
`default_nettype none

// Request channel: one rectangle request per beat.
interface skp_req_if;
    import skp_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [DIM_W-1:0] rect_width;
    logic [DIM_W-1:0] rect_height;

    modport source (output valid, output operation, output rect_width,
                    output rect_height, input ready);
    modport sink   (input valid, input operation, input rect_width,
                    input rect_height, output ready);
endinterface

// Response channel: one result per beat.
interface skp_rsp_if;
    import skp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    pos_x;
    logic [DIM_W-1:0]    pos_y;
    logic [COUNT_W-1:0]  node_count;

    modport source (output valid, output status, output pos_x, output pos_y,
                    output node_count, input ready);
    modport sink   (input valid, input status, input pos_x, input pos_y,
                    input node_count, output ready);
endinterface

`default_nettype wire

### sv/skyline_rectangle_packer.sv
`default_nettype none

// Skyline bottom-left rectangle packer. The skyline is held as a list of
// (x, level) nodes in two banks of a node memory; every request is worked
// through by one small sequencer and one shared add/compare datapath that
// reads at most one node per cycle, so the block takes one request at a time and
// holds req.ready low until its result sits in the output register. A search
// visits every start node and walks the segments it spans, which takes far
// less time when rectangles are narrow. Placing then finds the covered nodes
// and copies the new skyline, merged, into the other bank, alternating reads
// and writes; the single read port of the node memory paces all of this. A
// clear rebuilds the flat skyline in S_INIT0 and S_INIT1, and after reset the
// block does the same before it raises req.ready. The bin size registers may be
// written at any idle time and take effect for the next fit check; the
// skyline itself only follows a new bin width at the next clear. A result
// waiting in the output register does not stop the next request from being
// taken.
module skyline_rectangle_packer #(
    parameter int MAX_NODES  = skp_pkg::DEF_MAX_NODES,
    parameter int COORD_BITS = skp_pkg::DEF_COORD_BITS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [skp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [skp_pkg::CFG_DATA_W-1:0] cfg_data,
    skp_req_if.sink                            req,
    skp_rsp_if.source                          rsp
);
    import skp_pkg::*;

    // Index, count and arithmetic widths.
    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int NW = CW + 1;
    localparam int AW = IW + 1;
    localparam int VW = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
    localparam int CB = COORD_BITS;

    typedef enum logic [3:0] {
        S_INIT0, S_INIT1, S_IDLE, S_FIT_RD, S_FIT_RX, S_CHK,
        S_RS_RD, S_RS_RX, S_CNT, S_CP_RD, S_CP_WR, S_DONE
    } state_t;

    // Bin size registers.
    logic [DIM_W-1:0] bw_reg;
    logic [DIM_W-1:0] bh_reg;

    // Node memory: two banks, the live skyline in bank bank_reg.
    logic [CB-1:0] x_mem [2**AW];
    logic [CB-1:0] l_mem [2**AW];
    logic [CB-1:0] rd_x_reg;
    logic [CB-1:0] rd_l_reg;
    logic [IW-1:0] rd_idx;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [CB-1:0] wr_x;
    logic [CB-1:0] wr_l;

    // Sequencer state and working registers.
    state_t               state_reg;
    logic                 clr_reg;
    logic                 bank_reg;
    logic [CW-1:0]        used_reg;
    logic [OP_W-1:0]      op_reg;
    logic [DIM_W-1:0]     w_reg;
    logic [DIM_W-1:0]     h_reg;
    logic [IW-1:0]        i_reg;
    logic [IW-1:0]        e_reg;
    logic                 first_reg;
    logic signed [VW-1:0] left_reg;
    logic [CB-1:0]        y_reg;
    logic [CB-1:0]        prev_x_reg;
    logic                 found_reg;
    logic [IW-1:0]        best_reg;
    logic [CB-1:0]        best_x_reg;
    logic [CB-1:0]        best_y_reg;
    logic [VW-1:0]        right_reg;
    logic [CW-1:0]        r_reg;
    logic [CB-1:0]        last_lvl_reg;
    logic                 step_reg;
    logic [NW-1:0]        n_reg;
    logic [CW-1:0]        t_reg;
    logic [CW-1:0]        m_reg;
    logic [CB-1:0]        wl_reg;
    logic                 cp_mem_reg;
    logic [CB-1:0]        cp_x_reg;
    logic [CB-1:0]        cp_l_reg;

    // Pending result and output register.
    logic [STATUS_W-1:0]  res_status_reg;
    logic [DIM_W-1:0]     res_x_reg;
    logic [DIM_W-1:0]     res_y_reg;
    logic [COUNT_W-1:0]   res_cnt_reg;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  out_status_reg;
    logic [DIM_W-1:0]     out_x_reg;
    logic [DIM_W-1:0]     out_y_reg;
    logic [COUNT_W-1:0]   out_cnt_reg;

    // Shared datapath terms.
    logic signed [VW-1:0] seg;
    logic signed [VW-1:0] left_now;
    logic [CB-1:0]        y_now;
    logic                 fit_ok;
    logic                 fit_fail;
    logic                 more_starts;
    logic                 better;
    logic [CW-1:0]        best_c;
    logic                 cp_is_mem;
    logic [CW-1:0]        cp_src;
    logic [CB-1:0]        cp_sx;
    logic [CB-1:0]        cp_sl;
    logic [CB-1:0]        cp_vx;
    logic [CB-1:0]        cp_vl;
    logic                 cp_last;
    logic                 cp_keep;
    logic [CW-1:0]        m_after;
    logic [NW-1:0]        n_calc;

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.pos_x      = out_x_reg;
    assign rsp.pos_y      = out_y_reg;
    assign rsp.node_count = out_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg <= BIN_RESET;
            bh_reg <= BIN_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_BIN_WIDTH)
            begin
                bw_reg <= cfg_data;
            end
            else if (cfg_index == CFG_BIN_HEIGHT)
            begin
                bh_reg <= cfg_data;
            end
        end
    end

    // One write port and one registered read port on each array.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            l_mem[wr_addr] <= wr_l;
        end
        rd_x_reg <= x_mem[{bank_reg, rd_idx}];
        rd_l_reg <= l_mem[{bank_reg, rd_idx}];
    end

    // Fit walk: rd_x_reg/rd_l_reg hold node e_reg while in S_FIT_RX.
    always_comb
    begin
        seg      = $signed(VW'(rd_x_reg) - VW'(prev_x_reg));
        left_now = first_reg ? $signed(VW'(w_reg)) : (left_reg - seg);
        y_now    = (rd_l_reg > y_reg) ? rd_l_reg : y_reg;
        if (first_reg && (VW'(rd_x_reg) + VW'(w_reg) > VW'(bw_reg)))
        begin
            fit_ok   = 1'b0;
            fit_fail = 1'b1;
        end
        else if (!first_reg && (left_now <= $signed(VW'(0))))
        begin
            fit_ok   = 1'b1;
            fit_fail = 1'b0;
        end
        else
        begin
            fit_ok   = 1'b0;
            fit_fail = (CW'(e_reg) + CW'(1) >= used_reg)
                    || (VW'(y_now) + VW'(h_reg) > VW'(bh_reg));
        end
        better      = !found_reg || (y_reg < best_y_reg);
        more_starts = (CW'(i_reg) + CW'(1) < used_reg);
    end

    // Source of the next item of the rebuilt node list.
    always_comb
    begin
        best_c = CW'(best_reg);
        cp_src = t_reg;
        cp_sx  = best_x_reg;
        cp_sl  = CB'(VW'(best_y_reg) + VW'(h_reg));
        if (t_reg < best_c)
        begin
            cp_is_mem = 1'b1;
        end
        else if (t_reg == best_c)
        begin
            cp_is_mem = 1'b0;
        end
        else if (step_reg && (t_reg == best_c + CW'(1)))
        begin
            cp_is_mem = 1'b0;
            cp_sx     = CB'(right_reg);
            cp_sl     = last_lvl_reg;
        end
        else
        begin
            cp_is_mem = 1'b1;
            cp_src    = t_reg - best_c - CW'(1) - CW'(step_reg) + r_reg;
        end
        cp_vx   = cp_mem_reg ? rd_x_reg : cp_x_reg;
        cp_vl   = cp_mem_reg ? rd_l_reg : cp_l_reg;
        cp_last = (NW'(t_reg) + NW'(1) == n_reg);
        // Equal neighbours merge; the first node and the end marker stay.
        cp_keep = (t_reg == '0) || cp_last || (cp_vl != wl_reg);
        m_after = cp_keep ? (m_reg + CW'(1)) : m_reg;
        n_calc  = NW'(best_reg) + NW'(1) + NW'(step_reg) + NW'(used_reg - r_reg);
    end

    // Memory address and write control.
    always_comb
    begin
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_addr = {bank_reg, {IW{1'b0}}};
        wr_x    = '0;
        wr_l    = '0;
        unique case (state_reg)
            S_INIT0:
            begin
                wr_en = 1'b1;
            end
            S_INIT1:
            begin
                wr_en   = 1'b1;
                wr_addr = {bank_reg, IW'(1)};
                wr_x    = clr_reg ? CB'(bw_reg) : CB'(BIN_RESET);
            end
            S_FIT_RD: rd_idx = i_reg;
            S_FIT_RX: rd_idx = e_reg + IW'(1);
            S_RS_RD:  rd_idx = r_reg[IW-1:0];
            S_RS_RX:  rd_idx = r_reg[IW-1:0] + IW'(1);
            S_CP_RD:  rd_idx = cp_src[IW-1:0];
            S_CP_WR:
            begin
                wr_en   = cp_keep;
                wr_addr = {!bank_reg, m_reg[IW-1:0]};
                wr_x    = cp_vx;
                wr_l    = cp_last ? '0 : cp_vl;
            end
            default:
            begin
                rd_idx = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT0;
            clr_reg        <= 1'b0;
            bank_reg       <= 1'b0;
            used_reg       <= CW'(2);
            out_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
            first_reg      <= 1'b0;
        end
        else
        begin
            // A taken beat empties the output register unless a new result
            // moves into it at the same edge.
            if (rsp.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_INIT0:
                begin
                    state_reg <= S_INIT1;
                end
                S_INIT1:
                begin
                    used_reg       <= CW'(2);
                    res_status_reg <= ST_OK;
                    res_x_reg      <= '0;
                    res_y_reg      <= '0;
                    res_cnt_reg    <= COUNT_W'(2);
                    state_reg      <= clr_reg ? S_DONE : S_IDLE;
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg      <= req.operation;
                        w_reg       <= req.rect_width;
                        h_reg       <= req.rect_height;
                        i_reg       <= '0;
                        found_reg   <= 1'b0;
                        res_cnt_reg <= COUNT_W'(used_reg);
                        if (req.operation == OP_CLEAR)
                        begin
                            clr_reg   <= 1'b1;
                            state_reg <= S_INIT0;
                        end
                        else if (req.rect_width == '0 || req.rect_height == '0)
                        begin
                            res_status_reg <= ST_NOFIT;
                            res_x_reg      <= '0;
                            res_y_reg      <= '0;
                            state_reg      <= S_DONE;
                        end
                        else
                        begin
                            state_reg <= S_FIT_RD;
                        end
                    end
                end
                S_FIT_RD:
                begin
                    e_reg     <= i_reg;
                    first_reg <= 1'b1;
                    y_reg     <= '0;
                    state_reg <= S_FIT_RX;
                end
                S_FIT_RX:
                begin
                    if (fit_ok || fit_fail)
                    begin
                        if (fit_ok && better)
                        begin
                            found_reg  <= 1'b1;
                            best_reg   <= i_reg;
                            best_y_reg <= y_reg;
                        end
                        if (more_starts)
                        begin
                            i_reg     <= i_reg + IW'(1);
                            state_reg <= S_FIT_RD;
                        end
                        else
                        begin
                            state_reg <= S_CHK;
                        end
                    end
                    else
                    begin
                        left_reg   <= left_now;
                        y_reg      <= y_now;
                        prev_x_reg <= rd_x_reg;
                        e_reg      <= e_reg + IW'(1);
                        first_reg  <= 1'b0;
                    end
                end
                S_CHK:
                begin
                    if (!found_reg)
                    begin
                        res_status_reg <= ST_NOFIT;
                        res_x_reg      <= '0;
                        res_y_reg      <= '0;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        r_reg     <= CW'(best_reg);
                        state_reg <= S_RS_RD;
                    end
                end
                S_RS_RD:
                begin
                    // Node best is addressed on the read port now; its x is taken in S_RS_RX.
                    state_reg <= S_RS_RX;
                end
                S_RS_RX:
                begin
                    if (r_reg == CW'(best_reg))
                    begin
                        best_x_reg     <= rd_x_reg;
                        right_reg      <= VW'(rd_x_reg) + VW'(w_reg);
                        res_status_reg <= ST_OK;
                        res_x_reg      <= DIM_W'(rd_x_reg);
                        res_y_reg      <= DIM_W'(best_y_reg);
                        if (op_reg != OP_PLACE)
                        begin
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            last_lvl_reg <= rd_l_reg;
                            r_reg        <= r_reg + CW'(1);
                            if (r_reg + CW'(1) >= used_reg)
                            begin
                                step_reg  <= 1'b1;
                                state_reg <= S_CNT;
                            end
                        end
                    end
                    else if (VW'(rd_x_reg) < right_reg)
                    begin
                        last_lvl_reg <= rd_l_reg;
                        r_reg        <= r_reg + CW'(1);
                        if (r_reg + CW'(1) >= used_reg)
                        begin
                            step_reg  <= 1'b1;
                            state_reg <= S_CNT;
                        end
                    end
                    else
                    begin
                        step_reg  <= (VW'(rd_x_reg) > right_reg);
                        state_reg <= S_CNT;
                    end
                end
                S_CNT:
                begin
                    n_reg  <= n_calc;
                    t_reg  <= '0;
                    m_reg  <= '0;
                    if (n_calc > NW'(MAX_NODES))
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CP_RD;
                    end
                end
                S_CP_RD:
                begin
                    cp_mem_reg <= cp_is_mem;
                    cp_x_reg   <= cp_sx;
                    cp_l_reg   <= cp_sl;
                    state_reg  <= S_CP_WR;
                end
                S_CP_WR:
                begin
                    if (cp_keep)
                    begin
                        wl_reg <= cp_vl;
                    end
                    m_reg <= m_after;
                    t_reg <= t_reg + CW'(1);
                    if (cp_last)
                    begin
                        bank_reg    <= !bank_reg;
                        used_reg    <= m_after;
                        res_cnt_reg <= COUNT_W'(m_after);
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CP_RD;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_x_reg      <= res_x_reg;
                        out_y_reg      <= res_y_reg;
                        out_cnt_reg    <= res_cnt_reg;
                        clr_reg        <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A taken request keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while previous one still in work");

    // The skyline always holds its start node and end marker, within the store.
    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg >= CW'(2) && used_reg <= CW'(MAX_NODES))
        else $error("node count out of range");

    // The node memory is written only while building or copying a skyline.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == S_INIT0 || state_reg == S_INIT1
                   || state_reg == S_CP_WR))
        else $error("node memory written outside a build or copy");

    // Merging never writes more nodes than items it has consumed.
    a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CP_WR |-> m_reg <= t_reg)
        else $error("merge output ran ahead of its input");
`endif

endmodule

`default_nettype wire

### tb/skyline_rectangle_packer_test.sv
`timescale 1ns / 1ps

module skyline_rectangle_packer_test;
    import skp_pkg::*;

    localparam int NODES     = DEF_MAX_NODES;
    localparam int LIMIT     = 20_000_000;
    localparam int PER_PHASE = 210;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } rect_req_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    x;
        logic [DIM_W-1:0]    y;
        logic [COUNT_W-1:0]  count;
    } placement_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    skp_req_if req ();
    skp_rsp_if rsp ();

    skyline_rectangle_packer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // The predicted skyline and the bin size that the block should hold.
    longint sky_x [NODES];
    longint sky_lvl [NODES];
    int     sky_used;
    longint bin_w;
    longint bin_h;

    rect_req_t  pending_rects[$];
    placement_t expected_placements[$];

    int  mismatches;
    int  send_gap;
    int  recv_gap;
    int  hold_cycles;
    bit  hold_request;
    longint cycles;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Append a request to the tail of the pending queue.
    function automatic void queue_rect(rect_req_t r);
        pending_rects.insert(pending_rects.size(), r);
    endfunction

    // Rebuild the flat skyline from the current bin width.
    function automatic void flatten_skyline();
        for (int i = 0; i < NODES; i++)
        begin
            sky_x[i]   = 0;
            sky_lvl[i] = 0;
        end
        sky_x[1] = bin_w;
        sky_used = 2;
    endfunction

    // Does a w by h rectangle fit starting at node idx? Returns its base in y.
    function automatic bit fits_from(int idx, longint w, longint h, output longint base);
        longint left;
        longint y;
        int     j;
        left = w;
        y    = 0;
        j    = idx;
        base = 0;
        if (sky_x[idx] + w > bin_w)
            return 0;
        while (left > 0)
        begin
            if (j + 1 >= sky_used)
                return 0;
            if (sky_lvl[j] > y)
                y = sky_lvl[j];
            if (y + h > bin_h)
                return 0;
            left -= sky_x[j + 1] - sky_x[j];
            j++;
        end
        base = y;
        return 1;
    endfunction

    // Bottom-left search, and in place mode the commit with merging.
    function automatic placement_t pack_rect(rect_req_t r);
        placement_t res;
        longint     w, h, y, best_y, right, last_lvl;
        int         best, rr, n, k, m;
        bit         found, step;
        longint     tx [NODES + 2];
        longint     tl [NODES + 2];
        longint     nx [NODES];
        longint     nl [NODES];
        w = r.w;
        h = r.h;
        res.status = ST_NOFIT;
        res.x = '0;
        res.y = '0;
        found = 0;
        best = 0;
        best_y = 0;
        if (r.op == OP_CLEAR)
        begin
            flatten_skyline();
            res.status = ST_OK;
        end
        else if (w > 0 && h > 0)
        begin
            for (int i = 0; i < sky_used && i < NODES; i++)
            begin
                if (fits_from(i, w, h, y) && (!found || y < best_y))
                begin
                    found  = 1;
                    best   = i;
                    best_y = y;
                end
            end
            if (found)
            begin
                res.status = ST_OK;
                res.x = sky_x[best][DIM_W-1:0];
                res.y = best_y[DIM_W-1:0];
            end
            if (found && r.op == OP_PLACE)
            begin
                right = sky_x[best] + w;
                rr = best;
                while (rr < sky_used && sky_x[rr] < right)
                    rr++;
                last_lvl = sky_lvl[rr - 1];
                step = (rr >= sky_used) || (sky_x[rr] > right);
                n = best + 1 + (step ? 1 : 0) + (sky_used - rr);
                if (n > NODES)
                    res.status = ST_FULL;
                else
                begin
                    k = 0;
                    for (int i = 0; i < best; i++)
                    begin
                        tx[k] = sky_x[i];
                        tl[k] = sky_lvl[i];
                        k++;
                    end
                    tx[k] = sky_x[best];
                    tl[k] = (best_y + h) & 64'hFFFF;
                    k++;
                    if (step)
                    begin
                        tx[k] = right & 64'hFFFF;
                        tl[k] = last_lvl;
                        k++;
                    end
                    for (int i = rr; i < sky_used; i++)
                    begin
                        tx[k] = sky_x[i];
                        tl[k] = sky_lvl[i];
                        k++;
                    end
                    for (int i = 0; i < NODES; i++)
                    begin
                        nx[i] = 0;
                        nl[i] = 0;
                    end
                    // Segments level with their left neighbour are dropped,
                    // but the end marker always stays and keeps level zero.
                    m = 0;
                    for (int i = 0; i < k; i++)
                    begin
                        if (i > 0 && i + 1 < k && tl[i] == nl[m - 1])
                            continue;
                        nx[m] = tx[i];
                        nl[m] = (i + 1 < k) ? tl[i] : 0;
                        m++;
                    end
                    sky_x    = nx;
                    sky_lvl  = nl;
                    sky_used = m;
                end
            end
        end
        res.count = sky_used[COUNT_W-1:0];
        return res;
    endfunction

    // Mostly short gaps, now and then a long one, and runs with none.
    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    // Request driver: at most one assignment per signal per edge.
    always @(posedge clk or negedge rst_n)
    begin
        rect_req_t nxt;
        if (!rst_n)
        begin
            req.valid       <= 1'b0;
            req.operation   <= OP_FIND;
            req.rect_width  <= '0;
            req.rect_height <= '0;
            send_gap        <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                expected_placements.insert(expected_placements.size(),
                    pack_rect('{req.operation, req.rect_width, req.rect_height}));
            if (req.valid && !req.ready)
                ;
            else if (send_gap > 0)
            begin
                send_gap  <= send_gap - 1;
                req.valid <= 1'b0;
            end
            else if (pending_rects.size() > 0)
            begin
                nxt = pending_rects.pop_front();
                req.valid       <= 1'b1;
                req.operation   <= nxt.op;
                req.rect_width  <= nxt.w;
                req.rect_height <= nxt.h;
                send_gap        <= draw_gap();
            end
            else
                req.valid <= 1'b0;
        end
    end

    // Long hold-off of the result side, counted here on its own.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (hold_request && hold_cycles == 0)
            hold_cycles <= 3000;
        else if (hold_cycles > 1)
            hold_cycles <= hold_cycles - 1;
    end

    // Result monitor: compares each beat with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            rsp.ready  <= 1'b0;
            recv_gap   <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_placements.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("Unexpected beat: status %0d x %0d y %0d nodes %0d",
                                 rsp.status, rsp.pos_x, rsp.pos_y, rsp.node_count);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_placements.pop_front();
                    if (want.status !== rsp.status || want.x !== rsp.pos_x ||
                        want.y !== rsp.pos_y || want.count !== rsp.node_count)
                    begin
                        if (mismatches < 10)
                            $display("Mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                                     want.status, want.x, want.y, want.count,
                                     rsp.status, rsp.pos_x, rsp.pos_y, rsp.node_count);
                        mismatches <= mismatches + 1;
                    end
                end
            end
            if (hold_cycles > 1)
                rsp.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap  <= recv_gap - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                recv_gap  <= draw_gap();
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [DIM_W-1:0] draw_dim(longint bound);
        int p;
        longint cap;
        p = $urandom_range(0, 99);
        cap = (bound / 8 < 1) ? 1 : bound / 8;
        if (cap > 4096)
            cap = 4096;
        if (p < 80)
            return DIM_W'($urandom_range(1, 32'(cap)));
        if (p < 92)
            return DIM_W'($urandom_range(1, (bound < 1) ? 32'd1 : 32'(bound)));
        if (p < 95)
            return '0;
        return DIM_W'($urandom_range(0, 65535));
    endfunction

    function automatic rect_req_t draw_rect();
        rect_req_t r;
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            r.op = OP_PLACE;
        else if (p < 92)
            r.op = OP_FIND;
        else if (p < 96)
            r.op = OP_CLEAR;
        else
            r.op = OP_SPARE;
        r.w = draw_dim(bin_w);
        r.h = draw_dim(bin_h);
        return r;
    endfunction

    task automatic wait_idle();
        while (pending_rects.size() > 0 || expected_placements.size() > 0 || req.valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_BIN_WIDTH)
            bin_w = value;
        else
            bin_h = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus: directed corners, then random phases under several bin sizes.
    initial
    begin
        logic [DIM_W-1:0] widths [6];
        logic [DIM_W-1:0] heights [6];
        widths  = '{16'd1024, 16'd1, 16'd65535, 16'd64, 16'd300, 16'd7};
        heights = '{16'd1024, 16'd1, 16'd65535, 16'd200, 16'd1000, 16'd65535};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_BIN_WIDTH;
        cfg_data     = '0;
        cycles       = 0;
        hold_request = 1'b0;
        bin_w        = BIN_RESET;
        bin_h        = BIN_RESET;
        flatten_skyline();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero sizes, the full bin, oversized, the widest fields,
        // the unused operation code and a clear.
        queue_rect('{OP_FIND, 16'd1, 16'd1});
        queue_rect('{OP_FIND, 16'd0, 16'd5});
        queue_rect('{OP_PLACE, 16'd5, 16'd0});
        queue_rect('{OP_FIND, 16'd1025, 16'd1});
        queue_rect('{OP_PLACE, 16'd65535, 16'd65535});
        queue_rect('{OP_PLACE, 16'd100, 16'd50});
        queue_rect('{OP_PLACE, 16'd100, 16'd50});
        queue_rect('{OP_PLACE, 16'd200, 16'd30});
        queue_rect('{OP_SPARE, 16'd10, 16'd10});
        queue_rect('{OP_PLACE, 16'd624, 16'd20});
        queue_rect('{OP_PLACE, 16'd1024, 16'd1024});
        queue_rect('{OP_PLACE, 16'd1024, 16'd974});
        queue_rect('{OP_FIND, 16'd1, 16'd1});
        queue_rect('{OP_CLEAR, 16'd0, 16'd0});
        queue_rect('{OP_PLACE, 16'd1024, 16'd1024});
        queue_rect('{OP_CLEAR, 16'hFFFF, 16'hFFFF});
        // Narrow placements of rising height fill the node store.
        for (int i = 0; i < 70; i++)
            queue_rect('{OP_PLACE, 16'd1, 16'(i + 1)});
        queue_rect('{OP_CLEAR, 16'd0, 16'd0});
        wait_idle();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_BIN_WIDTH, widths[ph]);
            write_reg(CFG_BIN_HEIGHT, heights[ph]);
            queue_rect('{OP_CLEAR, 16'd0, 16'd0});
            for (int i = 0; i < PER_PHASE; i++)
                queue_rect(draw_rect());
            // Let the sender pile up against a stalled result side once.
            if (ph == 3)
            begin
                hold_request = 1'b1;
                wait (hold_cycles != 0);
                hold_request = 1'b0;
            end
            wait_idle();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_placements.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
